@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define RCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/rcc_pkg.sv @@
`default_nettype none

package rcc_pkg;

  localparam int ROW_W   = 64;
  localparam int SIZE_W  = 7;
  localparam int CNT_W   = 7;
  localparam int TOTAL_W = 22;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } rcc_state_e;

  // Sequencer controls for the pair unit and the output register.
  typedef struct packed {
    logic rd_en;
    logic emit;
    logic clear;
  } rcc_ctl_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [ROW_W-1:0] w);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < ROW_W; k++) begin
      n = n + CNT_W'(w[k]);
    end
    return n;
  endfunction

  // Number of column pairs among c common columns: c*(c-1)/2.
  function automatic logic [TOTAL_W-1:0] pair_count(input logic [CNT_W-1:0] c);
    logic [2*CNT_W-1:0] p;
    p = {{CNT_W{1'b0}}, c} * {{CNT_W{1'b0}}, c - CNT_W'(1)};
    return TOTAL_W'(p >> 1);
  endfunction

endpackage

`default_nettype wire

@@ sv/rcc_row_mem.sv @@
`default_nettype none

module rcc_row_mem import rcc_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [ROW_W-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [ROW_W-1:0] rdata_o
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/rcc_pair_unit.sv @@
`default_nettype none

module rcc_pair_unit import rcc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rcc_ctl_t           ctl_i,
  input  wire logic [ROW_W-1:0]   rd_data_i,
  input  wire logic [ROW_W-1:0]   row_i,
  output logic      [TOTAL_W-1:0] total_o,
  output logic                    busy_o
);

  logic               rd_vld_q;
  logic               c_vld_q;
  logic [CNT_W-1:0]   c_q;
  logic [TOTAL_W-1:0] total_q, total_d;

  // Stage 1: common columns of the stored row and the new row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      c_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= ctl_i.rd_en;
      c_vld_q  <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      c_q <= popcount(rd_data_i & row_i);
    end
  end

  // Stage 2: accumulate pairs, modulo the total width; clear or emit zeroes the total.
  always_comb begin
    total_d = total_q;
    if (ctl_i.clear || ctl_i.emit) begin
      total_d = '0;
    end else if (c_vld_q) begin
      total_d = total_q + pair_count(c_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  assign total_o = total_q;
  assign busy_o  = rd_vld_q | c_vld_q;

endmodule

`default_nettype wire

@@ sv/rcc_seq.sv @@
`default_nettype none

module rcc_seq import rcc_pkg::*; #(
  parameter int AW = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_fire_i,
  input  wire logic              cfg_fire_i,
  input  wire logic [SIZE_W-1:0] size_i,
  input  wire logic              pipe_busy_i,
  input  wire logic              out_busy_i,
  output logic                   in_ready_o,
  output rcc_ctl_t               ctl_o,
  output logic      [AW-1:0]     rd_addr_o,
  output logic      [AW-1:0]     wr_addr_o
);

  rcc_state_e        state_q, state_d;
  logic [SIZE_W-1:0] rows_seen_q, rows_seen_d;
  logic [SIZE_W-1:0] rd_cnt_q, rd_cnt_d;
  logic              last_row;

  assign last_row = (rows_seen_q + SIZE_W'(1)) >= size_i;

  // Next state and counters.
  always_comb begin
    state_d     = state_q;
    rows_seen_d = rows_seen_q;
    rd_cnt_d    = rd_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          rd_cnt_d = '0;
          state_d  = (rows_seen_q == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_cnt_d = rd_cnt_q + SIZE_W'(1);
        if (rd_cnt_d == rows_seen_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy_i) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_row) begin
          rows_seen_d = rows_seen_q + SIZE_W'(1);
          state_d     = ST_IDLE;
        end else if (!out_busy_i) begin
          rows_seen_d = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_fire_i) begin
      rows_seen_d = '0;
    end
  end

  // Outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    ctl_o.rd_en = 1'b0;
    ctl_o.emit  = 1'b0;
    ctl_o.clear = cfg_fire_i;
    case (state_q)
      ST_IDLE:   in_ready_o  = 1'b1;
      ST_SCAN:   ctl_o.rd_en = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: ctl_o.emit  = last_row && !out_busy_i;
      default:   ;
    endcase
  end

  assign rd_addr_o = rd_cnt_q[AW-1:0];
  assign wr_addr_o = rows_seen_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_seen_q <= '0;
      rd_cnt_q    <= '0;
    end else begin
      state_q     <= state_d;
      rows_seen_q <= rows_seen_d;
      rd_cnt_q    <= rd_cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/all_corner_rectangle_counter.sv @@
// Channel | Direction | Payload                      | Handshake
// cfg     | in        | grid_size_i   [6:0]          | cfg_valid_i / cfg_ready_o
// in      | in        | row_bits_i    [63:0]         | in_valid_i  / in_ready_o
// out     | out       | subgrid_total_o [21:0]       | out_valid_o / out_ready_i
//
// A row with earlier rows in its grid is compared against each of them before
// in_ready_o returns; the first row of a grid skips the scan. The row memory has
// one read port, so stored rows are read one at a time and pass through the read,
// popcount and accumulate stages. Reset clears control, rows seen, the total and
// sets the grid size to 64; the row memory is not cleared. Rows and grid-size
// writes are taken only while the block is idle; a pending write holds
// in_ready_o low. A finished total waits in the output register while further
// rows are taken; only the next grid completion holds until that total has been
// transferred.
`default_nettype none

module all_corner_rectangle_counter import rcc_pkg::*; #(
  parameter int MAX_SIZE = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [SIZE_W-1:0]  grid_size_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ROW_W-1:0]   row_bits_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [TOTAL_W-1:0] subgrid_total_o
);

`include "assert_macros.svh"

  localparam int                AW       = $clog2(MAX_SIZE);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIZE);

  logic               cfg_fire, in_fire, out_fire, out_busy, pipe_busy;
  logic               seq_idle;
  logic [SIZE_W-1:0]  grid_size_q, size_eff;
  logic [ROW_W-1:0]   col_mask, row_masked, row_q, rd_data;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [TOTAL_W-1:0] total;
  logic               out_valid_q;
  logic [TOTAL_W-1:0] out_total_q;
  rcc_ctl_t           ctl;

  // Take configuration only while idle; a write drops any partial grid and
  // wins over a row offered in the same cycle.
  assign cfg_ready_o = seq_idle;
  assign in_ready_o  = seq_idle & ~cfg_valid_i;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_q & out_ready_i;
  assign out_busy    = out_valid_q & ~out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_SIZE_RST;
    end else if (cfg_fire) begin
      grid_size_q <= grid_size_i;
    end
  end

  // Clamp the size to 1..MAX_SIZE.
  always_comb begin
    size_eff = grid_size_q;
    if (grid_size_q == '0) begin
      size_eff = SIZE_W'(1);
    end else if (grid_size_q > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end
  end

  // Drop columns at or beyond the grid size.
  always_comb begin
    for (int k = 0; k < ROW_W; k++) begin
      col_mask[k] = (SIZE_W'(k) < size_eff) || (k >= 2**SIZE_W - 1);
    end
  end

  assign row_masked = row_bits_i & col_mask;

  // Hold the new row for the whole scan.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q <= row_masked;
    end
  end

  rcc_seq #(
    .AW (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .cfg_fire_i  (cfg_fire),
    .size_i      (size_eff),
    .pipe_busy_i (pipe_busy),
    .out_busy_i  (out_busy),
    .in_ready_o  (seq_idle),
    .ctl_o       (ctl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr)
  );

  // The new row goes to its slot at transfer; the scan only reads lower slots,
  // so write and reads never meet on one entry.
  rcc_row_mem #(
    .DEPTH (MAX_SIZE),
    .AW    (AW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (wr_addr),
    .wdata_i (row_masked),
    .re_i    (ctl.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  rcc_pair_unit u_pair (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_data_i (rd_data),
    .row_i     (row_q),
    .total_o   (total),
    .busy_o    (pipe_busy)
  );

  // Output register: load the total when a grid completes, hold until transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_total_q <= total;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign subgrid_total_o = out_total_q;

  `RCC_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_busy, !ctl.emit, "total overwritten")
  `RCC_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, ctl.emit, out_valid_o, "emitted total not shown")
  `RCC_ASSERT_IMP(a_read_busy, clk_i, rst_ni, ctl.rd_en, !in_ready_o, "row read while taking rows")
  `RCC_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_fire, !in_ready_o, "second row mid-item")

endmodule

`default_nettype wire
